// ----- rtl/wtt_pkg.sv -----
// ----------------------------------------------------------------------------
// wtt_pkg
// shared types and constants of the wheel turn tracker
// ----------------------------------------------------------------------------
package wtt_pkg;

  localparam logic [7:0] STRAIGHT           = 8'd90;
  localparam logic [7:0] LEFT_REV_BELOW     = 8'd45;
  localparam logic [7:0] RIGHT_REV_ABOVE    = 8'd135;
  localparam logic [6:0] DPC_RESET          = 7'd15;

  typedef struct packed {
    logic       left_level;
    logic       right_level;
    logic       set_turn;
    logic [7:0] turn_command;
  } in_t;

  typedef struct packed {
    logic               turn_done;
    logic signed [15:0] estimated_angle;
    logic signed [15:0] left_total;
    logic signed [15:0] right_total;
    logic [7:0]         target_angle_out;
  } res_t;

endpackage

// ----- rtl/wtt_side.sv -----
// ----------------------------------------------------------------------------
// wtt_side
// falling edge detector with arming flag and up/down edge counter, one wheel
// ----------------------------------------------------------------------------
module wtt_side #(
  parameter int unsigned CW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          level_i,
  input  logic          reverse_i,
  output logic [CW-1:0] count_d_o
);

  logic          armed_q, armed_d;
  logic [CW-1:0] count_q, count_d;

  always_comb begin
    armed_d = armed_q;
    count_d = count_q;
    if (!armed_q && !level_i) begin
      count_d = reverse_i ? count_q - CW'(1) : count_q + CW'(1);
      armed_d = 1'b1;
    end else if (armed_q && level_i) begin
      armed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      count_q <= '0;
    end else if (en_i) begin
      armed_q <= armed_d;
      count_q <= count_d;
    end
  end

  assign count_d_o = count_d;

endmodule

// ----- rtl/wtt_core.sv -----
// ----------------------------------------------------------------------------
// wtt_core
// turn state, origin capture, angle estimate and completion test
// ----------------------------------------------------------------------------
module wtt_core import wtt_pkg::*; #(
  parameter int unsigned CW = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_t        item_i,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_data_i,
  output res_t       res_o
);

  localparam int unsigned PW = CW + 9;
  localparam int unsigned EW = CW + 10;
  localparam logic signed [EW-1:0] MID    = signed'(EW'(STRAIGHT));
  localparam logic signed [EW-1:0] SAT_HI = signed'(EW'(32767));
  localparam logic signed [EW-1:0] SAT_LO = signed'(-EW'(32768));

  logic [6:0]         dpc_q;
  logic [7:0]         target_q, target_d;
  logic signed [15:0] angle_q, angle_d;
  logic               active_q, active_d;
  logic [CW-1:0]      orig_l_q, orig_r_q, orig_l_d, orig_r_d;

  logic [7:0]         tgt_eff;
  logic [CW-1:0]      count_l_d, count_r_d;
  logic               start;
  logic signed [CW-1:0] dl, dr;
  logic signed [CW:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [EW-1:0] est;
  logic signed [15:0]   angle_sat;
  logic signed [15:0]   tgt_s;
  logic                 hit, done;
  logic signed [31:0]   ext_l, ext_r;

  assign tgt_eff = item_i.set_turn ? item_i.turn_command : target_q;

  wtt_side #(.CW(CW)) u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (step_i),
    .level_i   (item_i.left_level),
    .reverse_i (tgt_eff < LEFT_REV_BELOW),
    .count_d_o (count_l_d)
  );

  wtt_side #(.CW(CW)) u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (step_i),
    .level_i   (item_i.right_level),
    .reverse_i (tgt_eff > RIGHT_REV_ABOVE),
    .count_d_o (count_r_d)
  );

  assign start    = (tgt_eff != STRAIGHT) && !active_q;
  assign orig_l_d = start ? count_l_d : orig_l_q;
  assign orig_r_d = start ? count_r_d : orig_r_q;

  assign dl = signed'(count_l_d - orig_l_d);
  assign dr = signed'(count_r_d - orig_r_d);

  always_comb begin
    if (tgt_eff < STRAIGHT) begin
      diff = (CW+1)'(dr) - (CW+1)'(dl);
    end else begin
      diff = (CW+1)'(dl) - (CW+1)'(dr);
    end
  end

  assign prod = PW'(signed'({1'b0, dpc_q})) * PW'(diff);

  always_comb begin
    if (tgt_eff < STRAIGHT) begin
      est = MID - EW'(prod);
    end else begin
      est = MID + EW'(prod);
    end
  end

  always_comb begin
    if (est > SAT_HI) begin
      angle_sat = 16'sd32767;
    end else if (est < SAT_LO) begin
      angle_sat = -16'sd32768;
    end else begin
      angle_sat = est[15:0];
    end
  end

  assign tgt_s = signed'({8'd0, tgt_eff});
  assign hit   = ((tgt_eff < STRAIGHT) && (angle_sat <= tgt_s)) ||
                 ((tgt_eff > STRAIGHT) && (angle_sat >= tgt_s));

  always_comb begin
    target_d = tgt_eff;
    angle_d  = angle_q;
    active_d = active_q | start;
    done     = 1'b0;
    if ((active_q | start) && (tgt_eff != STRAIGHT)) begin
      angle_d = angle_sat;
      if (hit) begin
        target_d = STRAIGHT;
        angle_d  = signed'({8'd0, STRAIGHT});
        active_d = 1'b0;
        done     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpc_q <= DPC_RESET;
    end else if (cfg_we_i) begin
      dpc_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= STRAIGHT;
      angle_q  <= '0;
      active_q <= 1'b0;
      orig_l_q <= '0;
      orig_r_q <= '0;
    end else if (step_i) begin
      target_q <= target_d;
      angle_q  <= angle_d;
      active_q <= active_d;
      orig_l_q <= orig_l_d;
      orig_r_q <= orig_r_d;
    end
  end

  // sign extend counts, then keep the low 16 bits
  assign ext_l = 32'(signed'(count_l_d));
  assign ext_r = 32'(signed'(count_r_d));

  assign res_o.turn_done        = done;
  assign res_o.estimated_angle  = angle_d;
  assign res_o.left_total       = ext_l[15:0];
  assign res_o.right_total      = ext_r[15:0];
  assign res_o.target_angle_out = target_d;

endmodule

// ----- rtl/wheel_turn_tracker.sv -----
// ----------------------------------------------------------------------------
// wheel_turn_tracker
// wheel encoder turn monitor: edge counts, heading estimate, turn completion
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) carries one encoder sample word:
//   both wheel levels and an optional new turn command (set_turn_i).
//   output channel (out_valid_o / out_ready_i) returns one result word per
//   input word: done flag, estimated angle, both wheel totals, target.
//   cfg_we_i writes degrees_per_count from cfg_data_i; write it
//   only while no word is in flight.
//   path: an accepted word sits in the input register, then its result is
//   registered in the result register and shown on the output.
//   throughput: one word per cycle while out_ready_i is high; the state update
//   is one pass of logic between the input and result registers.
//   stall: while out_ready_i is low the result holds and one more word may
//   wait in the input register; in_ready_o drops only when both are full.
//   reset: both registers empty, target 90, estimate 0, counts, origins and
//   arming flags cleared, degrees_per_count 15.
// ----------------------------------------------------------------------------
module wheel_turn_tracker import wtt_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               left_level_i,
  input  logic               right_level_i,
  input  logic               set_turn_i,
  input  logic [7:0]         turn_command_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               turn_done_o,
  output logic signed [15:0] estimated_angle_o,
  output logic signed [15:0] left_total_o,
  output logic signed [15:0] right_total_o,
  output logic [7:0]         target_angle_out_o
);

  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  res_t res_q, res_d;
  logic advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.left_level   <= left_level_i;
      in_q.right_level  <= right_level_i;
      in_q.set_turn     <= set_turn_i;
      in_q.turn_command <= turn_command_i;
    end
  end

  wtt_core #(.CW(COUNT_BITS)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign turn_done_o        = res_q.turn_done;
  assign estimated_angle_o  = res_q.estimated_angle;
  assign left_total_o       = res_q.left_total;
  assign right_total_o      = res_q.right_total;
  assign target_angle_out_o = res_q.target_angle_out;

endmodule

// ----- rtl/wtt_checker.sv -----
// ----------------------------------------------------------------------------
// wtt_checker
// port level checks of the wheel turn tracker, bound to the top level
// ----------------------------------------------------------------------------
module wtt_checker import wtt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               turn_done_o,
  input logic signed [15:0] estimated_angle_o,
  input logic signed [15:0] left_total_o,
  input logic signed [15:0] right_total_o,
  input logic [7:0]         target_angle_out_o
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(turn_done_o) &&
      $stable(estimated_angle_o) && $stable(left_total_o) &&
      $stable(right_total_o) && $stable(target_angle_out_o))
    else $error("result word changed while stalled");

  // input backs up only behind a stalled full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without output stall");

  // an accepted word is always followed by a valid result on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("result missing after accepted word");

  // completion returns target and estimate to straight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && turn_done_o |-> target_angle_out_o == STRAIGHT &&
      estimated_angle_o == signed'({8'd0, STRAIGHT}))
    else $error("done without return to straight");

endmodule

bind wheel_turn_tracker wtt_checker u_wtt_checker (.*);
